// ===== hdl/cau_pkg.sv =====
// shared types, constants and helpers of the complex arithmetic unit
// no dependencies; used by cau_step and complex_arithmetic_unit
package cau_pkg;

  localparam int DATA_W            = 16;
  localparam int FRAC_BITS_DEF     = 8;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_TAB_N        = 24;
  localparam int QUOT_W            = 16;   // divider quotient bits below overflow
  localparam int SQRT_STEPS        = 16;   // root bits of a 32-bit radicand
  localparam int DIV_W             = 50;   // divider remainder, fits FRAC_BITS up to 14
  localparam int DEN2_W            = 33;
  localparam int SQ_W              = 32;
  localparam int SQR_W             = 33;
  localparam int CX_W              = 36;
  localparam int CZ_W              = 34;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_CONJ  = 3'd4;
  localparam logic [2:0] OP_SCALE = 3'd5;
  localparam logic [2:0] OP_EQ    = 3'd6;
  localparam logic [2:0] OP_POLAR = 3'd7;

  localparam logic signed [CZ_W-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [CZ_W-1:0] PH_MAX      = 34'sd25736;
  localparam logic signed [CZ_W-1:0] PH_RND      = 34'sd65536;
  localparam int                     PH_SHIFT    = 17;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] rr;
    logic signed [DATA_W-1:0] ri;
    logic                     sat;
    logic                     eq;
    logic                     dz;
    logic                     ovf_re;
    logic                     ovf_im;
    logic                     neg_re;
    logic                     neg_im;
    logic [DIV_W-1:0]         rem_re;
    logic [DIV_W-1:0]         rem_im;
    logic [DEN2_W-1:0]        den2;
    logic [QUOT_W-1:0]        q_re;
    logic [QUOT_W-1:0]        q_im;
    logic [SQ_W-1:0]          sq_v;
    logic [SQR_W-1:0]         sq_r;
    logic signed [CX_W-1:0]   cx;
    logic signed [CX_W-1:0]   cy;
    logic signed [CZ_W-1:0]   cz;
    logic                     czero;
  } pipe_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic signed [CZ_W-1:0] atan_lut(input int unsigned idx);
    logic signed [CZ_W-1:0] a;
    unique case (idx)
      0:  a = 34'sd843314856;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043836;
      3:  a = 34'sd133525158;
      4:  a = 34'sd67021686;
      5:  a = 34'sd33543515;
      6:  a = 34'sd16775850;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194282;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048575;
      11: a = 34'sd524287;
      12: a = 34'sd262143;
      13: a = 34'sd131071;
      14: a = 34'sd65535;
      15: a = 34'sd32767;
      16: a = 34'sd16383;
      17: a = 34'sd8191;
      18: a = 34'sd4095;
      19: a = 34'sd2047;
      20: a = 34'sd1023;
      21: a = 34'sd511;
      22: a = 34'sd255;
      23: a = 34'sd127;
      default: a = '0;
    endcase
    return a;
  endfunction

  // {clip flag, value} of a signed value clipped to 16 bits
  function automatic logic [DATA_W:0] sat16(input logic signed [39:0] v);
    logic [DATA_W:0] r;
    if (v > 40'sd32767) begin
      r = {1'b1, 16'h7FFF};
    end else if (v < -40'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

endpackage

// ===== hdl/complex_arithmetic_unit.sv =====
// top level of the pipelined complex-number alu
// depends on cau_pkg and cau_step
//
//   port group  dir  payload
//   in_*        in   req_type, a_re, a_im, b_re, b_im, scale_factor
//   out_*       out  res_re, res_im, magnitude, phase_angle, is_equal,
//                    div_by_zero, saturated
//
// one beat in and one beat out per cycle unless the output stalls; the iteration chain
// gives 16 divider/root bits and one cordic rotation a stage
// all stages move together: a stalled output holds every stage, bubbles included
// reset clears the valid bits only; no clearing pass
module complex_arithmetic_unit #(
  parameter int FRAC_BITS     = cau_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = cau_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_req_type,
  input  logic signed [cau_pkg::DATA_W-1:0] in_a_re,
  input  logic signed [cau_pkg::DATA_W-1:0] in_a_im,
  input  logic signed [cau_pkg::DATA_W-1:0] in_b_re,
  input  logic signed [cau_pkg::DATA_W-1:0] in_b_im,
  input  logic signed [cau_pkg::DATA_W-1:0] in_scale_factor,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cau_pkg::DATA_W-1:0] out_res_re,
  output logic signed [cau_pkg::DATA_W-1:0] out_res_im,
  output logic [cau_pkg::DATA_W-1:0]        out_magnitude,
  output logic signed [cau_pkg::DATA_W-1:0] out_phase_angle,
  output logic                              out_is_equal,
  output logic                              out_div_by_zero,
  output logic                              out_saturated
);

  localparam int DW     = cau_pkg::DATA_W;
  localparam int DVW    = cau_pkg::DIV_W;
  localparam int CXW    = cau_pkg::CX_W;
  localparam int CZW    = cau_pkg::CZ_W;
  localparam int QW     = cau_pkg::QUOT_W;
  localparam int CS_EFF = (CORDIC_STAGES < cau_pkg::ATAN_TAB_N) ?
                          CORDIC_STAGES : cau_pkg::ATAN_TAB_N;
  localparam int NSTEP  = (CS_EFF > QW) ? CS_EFF : QW;
  localparam logic signed [32:0] RND_HALF = 33'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic [2:0]          op;
    logic signed [31:0]  p_rr;
    logic signed [31:0]  p_ii;
    logic signed [31:0]  p_ri;
    logic signed [31:0]  p_ir;
    logic signed [31:0]  p_bbr;
    logic signed [31:0]  p_bbi;
    logic signed [31:0]  p_aar;
    logic signed [31:0]  p_aai;
    logic signed [31:0]  p_scr;
    logic signed [31:0]  p_sci;
    logic signed [16:0]  e_re;
    logic signed [16:0]  e_im;
    logic                eq;
    logic signed [CXW-1:0] cx;
    logic signed [CXW-1:0] cy;
    logic signed [CZW-1:0] cz;
    logic                czero;
  } s1_t;

  typedef struct packed {
    logic [2:0]          op;
    logic signed [16:0]  e_re;
    logic signed [16:0]  e_im;
    logic                eq;
    logic signed [32:0]  pr;
    logic signed [32:0]  pi;
    logic signed [32:0]  num_re;
    logic signed [32:0]  num_im;
    logic [31:0]         den;
    logic [31:0]         sqv;
    logic signed [CXW-1:0] cx;
    logic signed [CXW-1:0] cy;
    logic signed [CZW-1:0] cz;
    logic                czero;
  } s2_t;

  logic           en;
  logic           s1_vld_r;
  s1_t            s1_r;
  s1_t            s1_nxt;
  logic           s2_vld_r;
  s2_t            s2_r;
  s2_t            s2_nxt;
  logic           p3_vld_r;
  cau_pkg::pipe_t p3_r;
  cau_pkg::pipe_t p3_nxt;
  logic           stg_vld [0:NSTEP];
  cau_pkg::pipe_t stg_d   [0:NSTEP];

  logic signed [CXW-1:0] x0;
  logic signed [CXW-1:0] y0;
  logic signed [32:0]    rnd_re;
  logic signed [32:0]    rnd_im;
  logic [32:0]           abs_re;
  logic [32:0]           abs_im;
  logic [DVW-1:0]        n_re;
  logic [DVW-1:0]        n_im;
  logic [DVW-1:0]        d_lim;
  logic [DW:0]           c_re;
  logic [DW:0]           c_im;

  logic                  out_valid_r;
  logic signed [DW-1:0]  res_re_r;
  logic signed [DW-1:0]  res_im_r;
  logic [DW-1:0]         mag_r;
  logic signed [DW-1:0]  phase_r;
  logic                  eq_r;
  logic                  dz_r;
  logic                  sat_r;
  logic signed [DW-1:0]  res_re_nxt;
  logic signed [DW-1:0]  res_im_nxt;
  logic [DW-1:0]         mag_nxt;
  logic signed [DW-1:0]  phase_nxt;
  logic                  eq_nxt;
  logic                  dz_nxt;
  logic                  sat_nxt;

  cau_pkg::pipe_t        f;
  logic [QW:0]           qm_re;
  logic [QW:0]           qm_im;
  logic signed [QW+1:0]  qv_re;
  logic signed [QW+1:0]  qv_im;
  logic [DW:0]           qc_re;
  logic [DW:0]           qc_im;
  logic signed [CZW-1:0] zr;
  logic signed [CZW-1:0] zc;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 1: products, add/sub/conjugate, compare, cordic quadrant fold
  always_comb begin
    s1_nxt.op    = in_req_type;
    s1_nxt.p_rr  = in_a_re * in_b_re;
    s1_nxt.p_ii  = in_a_im * in_b_im;
    s1_nxt.p_ri  = in_a_re * in_b_im;
    s1_nxt.p_ir  = in_a_im * in_b_re;
    s1_nxt.p_bbr = in_b_re * in_b_re;
    s1_nxt.p_bbi = in_b_im * in_b_im;
    s1_nxt.p_aar = in_a_re * in_a_re;
    s1_nxt.p_aai = in_a_im * in_a_im;
    s1_nxt.p_scr = in_a_re * in_scale_factor;
    s1_nxt.p_sci = in_a_im * in_scale_factor;
    s1_nxt.eq    = (in_a_re == in_b_re) && (in_a_im == in_b_im);
    if (in_req_type == cau_pkg::OP_SUB) begin
      s1_nxt.e_re = 17'(in_a_re) - 17'(in_b_re);
      s1_nxt.e_im = 17'(in_a_im) - 17'(in_b_im);
    end else if (in_req_type == cau_pkg::OP_CONJ) begin
      s1_nxt.e_re = 17'(in_a_re);
      s1_nxt.e_im = -17'(in_a_im);
    end else begin
      s1_nxt.e_re = 17'(in_a_re) + 17'(in_b_re);
      s1_nxt.e_im = 17'(in_a_im) + 17'(in_b_im);
    end
    x0 = CXW'(in_a_re) <<< 16;
    y0 = CXW'(in_a_im) <<< 16;
    s1_nxt.czero = (in_a_re == '0) && (in_a_im == '0);
    if (in_a_re < 0) begin
      if (in_a_im >= 0) begin
        s1_nxt.cx = y0;
        s1_nxt.cy = -x0;
        s1_nxt.cz = cau_pkg::ANG_HALF_PI;
      end else begin
        s1_nxt.cx = -y0;
        s1_nxt.cy = x0;
        s1_nxt.cz = -cau_pkg::ANG_HALF_PI;
      end
    end else begin
      s1_nxt.cx = x0;
      s1_nxt.cy = y0;
      s1_nxt.cz = '0;
    end
  end

  // stage 2: sums of products
  always_comb begin
    s2_nxt.op     = s1_r.op;
    s2_nxt.e_re   = s1_r.e_re;
    s2_nxt.e_im   = s1_r.e_im;
    s2_nxt.eq     = s1_r.eq;
    if (s1_r.op == cau_pkg::OP_SCALE) begin
      s2_nxt.pr = 33'(s1_r.p_scr);
      s2_nxt.pi = 33'(s1_r.p_sci);
    end else begin
      s2_nxt.pr = 33'(s1_r.p_rr) - 33'(s1_r.p_ii);
      s2_nxt.pi = 33'(s1_r.p_ri) + 33'(s1_r.p_ir);
    end
    s2_nxt.num_re = 33'(s1_r.p_rr) + 33'(s1_r.p_ii);
    s2_nxt.num_im = 33'(s1_r.p_ir) - 33'(s1_r.p_ri);
    s2_nxt.den    = s1_r.p_bbr[31:0] + s1_r.p_bbi[31:0];
    s2_nxt.sqv    = s1_r.p_aar[31:0] + s1_r.p_aai[31:0];
    s2_nxt.cx     = s1_r.cx;
    s2_nxt.cy     = s1_r.cy;
    s2_nxt.cz     = s1_r.cz;
    s2_nxt.czero  = s1_r.czero;
  end

  // stage 3: round and clip products, clip sums, set up the divider with rounding folded in
  always_comb begin
    rnd_re = (s2_r.pr + RND_HALF) >>> FRAC_BITS;
    rnd_im = (s2_r.pi + RND_HALF) >>> FRAC_BITS;
    if (s2_r.op == cau_pkg::OP_MUL || s2_r.op == cau_pkg::OP_SCALE) begin
      c_re = cau_pkg::sat16(40'(rnd_re));
      c_im = cau_pkg::sat16(40'(rnd_im));
    end else begin
      c_re = cau_pkg::sat16(40'(s2_r.e_re));
      c_im = cau_pkg::sat16(40'(s2_r.e_im));
    end
    abs_re = s2_r.num_re[32] ? 33'(-s2_r.num_re) : 33'(s2_r.num_re);
    abs_im = s2_r.num_im[32] ? 33'(-s2_r.num_im) : 33'(s2_r.num_im);
    // q = floor((2n + d) / 2d) with n = |num| << FRAC_BITS
    n_re   = ((DVW'(abs_re) << FRAC_BITS) << 1) + DVW'(s2_r.den);
    n_im   = ((DVW'(abs_im) << FRAC_BITS) << 1) + DVW'(s2_r.den);
    d_lim  = DVW'({s2_r.den, 1'b0}) << QW;

    p3_nxt.op     = s2_r.op;
    p3_nxt.rr     = c_re[DW-1:0];
    p3_nxt.ri     = c_im[DW-1:0];
    p3_nxt.sat    = c_re[DW] | c_im[DW];
    p3_nxt.eq     = s2_r.eq;
    p3_nxt.dz     = (s2_r.den == '0);
    p3_nxt.ovf_re = (n_re >= d_lim);
    p3_nxt.ovf_im = (n_im >= d_lim);
    p3_nxt.neg_re = s2_r.num_re[32];
    p3_nxt.neg_im = s2_r.num_im[32];
    p3_nxt.rem_re = n_re;
    p3_nxt.rem_im = n_im;
    p3_nxt.den2   = {s2_r.den, 1'b0};
    p3_nxt.q_re   = '0;
    p3_nxt.q_im   = '0;
    p3_nxt.sq_v   = s2_r.sqv;
    p3_nxt.sq_r   = '0;
    p3_nxt.cx     = s2_r.cx;
    p3_nxt.cy     = s2_r.cy;
    p3_nxt.cz     = s2_r.cz;
    p3_nxt.czero  = s2_r.czero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      p3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      p3_r <= p3_nxt;
    end
  end

  assign stg_vld[0] = p3_vld_r;
  assign stg_d[0]   = p3_r;

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    cau_step #(
      .STEP   (k),
      .CS_EFF (CS_EFF)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (stg_vld[k]),
      .in_d    (stg_d[k]),
      .out_vld (stg_vld[k+1]),
      .out_d   (stg_d[k+1])
    );
  end

  // final stage: sign and clip quotients, round root and angle, pick fields
  always_comb begin
    f     = stg_d[NSTEP];
    qm_re = f.ovf_re ? (QW+1)'(1) << QW : {1'b0, f.q_re};
    qm_im = f.ovf_im ? (QW+1)'(1) << QW : {1'b0, f.q_im};
    qv_re = f.neg_re ? -$signed({1'b0, qm_re}) : $signed({1'b0, qm_re});
    qv_im = f.neg_im ? -$signed({1'b0, qm_im}) : $signed({1'b0, qm_im});
    qc_re = cau_pkg::sat16(40'(qv_re));
    qc_im = cau_pkg::sat16(40'(qv_im));
    zr    = (f.cz + cau_pkg::PH_RND) >>> cau_pkg::PH_SHIFT;
    if (f.czero) begin
      zc = '0;
    end else if (zr > cau_pkg::PH_MAX) begin
      zc = cau_pkg::PH_MAX;
    end else if (zr < -cau_pkg::PH_MAX) begin
      zc = -cau_pkg::PH_MAX;
    end else begin
      zc = zr;
    end

    res_re_nxt = '0;
    res_im_nxt = '0;
    mag_nxt    = '0;
    phase_nxt  = '0;
    eq_nxt     = 1'b0;
    dz_nxt     = 1'b0;
    sat_nxt    = 1'b0;
    unique case (f.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL,
      cau_pkg::OP_CONJ, cau_pkg::OP_SCALE: begin
        res_re_nxt = f.rr;
        res_im_nxt = f.ri;
        sat_nxt    = f.sat;
      end
      cau_pkg::OP_DIV: begin
        if (f.dz) begin
          dz_nxt = 1'b1;
        end else begin
          res_re_nxt = qc_re[DW-1:0];
          res_im_nxt = qc_im[DW-1:0];
          sat_nxt    = qc_re[DW] | qc_im[DW];
        end
      end
      cau_pkg::OP_EQ: begin
        eq_nxt = f.eq;
      end
      cau_pkg::OP_POLAR: begin
        mag_nxt   = DW'(f.sq_r + cau_pkg::SQR_W'({1'b0, f.sq_v} > f.sq_r));
        phase_nxt = zc[DW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stg_vld[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      mag_r    <= mag_nxt;
      phase_r  <= phase_nxt;
      eq_r     <= eq_nxt;
      dz_r     <= dz_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_re      = res_re_r;
  assign out_res_im      = res_im_r;
  assign out_magnitude   = mag_r;
  assign out_phase_angle = phase_r;
  assign out_is_equal    = eq_r;
  assign out_div_by_zero = dz_r;
  assign out_saturated   = sat_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |-> out_res_re == '0 && out_res_im == '0 && !out_saturated)
    else $error("divide by zero beat carries a nonzero result");

  a_phase_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_phase_angle <= 16'sd25736 && out_phase_angle >= -16'sd25736)
    else $error("phase out of range");

  a_eq_vs_polar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_equal |-> out_magnitude == '0 && !out_saturated)
    else $error("compare beat carries polar or clip fields");

  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(stg_d[NSTEP]) && $stable(stg_vld[NSTEP]))
    else $error("iteration chain moved during a stall");

  a_chain_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && stg_vld[NSTEP] |=> out_valid)
    else $error("finished beat lost before the output register");

endmodule

// ===== hdl/cau_step.sv =====
// one registered iteration stage: a restoring divider bit for both quotients,
// a square-root digit and a vectoring cordic rotation, each if STEP is in range; depends on cau_pkg
module cau_step #(
  parameter int STEP   = 0,
  parameter int CS_EFF = cau_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  cau_pkg::pipe_t in_d,
  output logic           out_vld,
  output cau_pkg::pipe_t out_d
);

  localparam int  DW      = cau_pkg::DIV_W;
  localparam int  SRW     = cau_pkg::SQR_W;
  localparam int  SW      = cau_pkg::SQ_W;
  localparam bit  DO_DIV  = (STEP < cau_pkg::QUOT_W);
  localparam bit  DO_SQ   = (STEP < cau_pkg::SQRT_STEPS);
  localparam bit  DO_COR  = (STEP < CS_EFF);
  localparam int  QI      = DO_DIV ? cau_pkg::QUOT_W - 1 - STEP : 0;
  localparam int  SQB     = DO_SQ ? 2 * (cau_pkg::SQRT_STEPS - 1 - STEP) : 0;
  localparam int  AIDX    = DO_COR ? STEP : 0;
  localparam logic signed [cau_pkg::CZ_W-1:0] ATAN = cau_pkg::atan_lut(AIDX);

  logic                             vld_r;
  cau_pkg::pipe_t                   d_r;
  cau_pkg::pipe_t                   d_nxt;
  logic [DW-1:0]                    dsub;
  logic [SRW-1:0]                   sq_bit;
  logic [SRW-1:0]                   sq_try;
  logic signed [cau_pkg::CX_W-1:0]  dx;
  logic signed [cau_pkg::CX_W-1:0]  dy;

  assign dsub   = DW'(in_d.den2) << QI;
  assign sq_bit = SRW'(1) << SQB;
  assign sq_try = in_d.sq_r + sq_bit;
  assign dx     = in_d.cy >>> STEP;
  assign dy     = in_d.cx >>> STEP;

  always_comb begin
    d_nxt = in_d;
    if (DO_DIV) begin
      if (in_d.rem_re >= dsub) begin
        d_nxt.rem_re   = in_d.rem_re - dsub;
        d_nxt.q_re[QI] = 1'b1;
      end
      if (in_d.rem_im >= dsub) begin
        d_nxt.rem_im   = in_d.rem_im - dsub;
        d_nxt.q_im[QI] = 1'b1;
      end
    end
    if (DO_SQ) begin
      if ({1'b0, in_d.sq_v} >= sq_try) begin
        d_nxt.sq_v = SW'({1'b0, in_d.sq_v} - sq_try);
        d_nxt.sq_r = (in_d.sq_r >> 1) + sq_bit;
      end else begin
        d_nxt.sq_r = in_d.sq_r >> 1;
      end
    end
    if (DO_COR) begin
      // rotate toward the x axis
      if (!in_d.cy[cau_pkg::CX_W-1]) begin
        d_nxt.cx = in_d.cx + dx;
        d_nxt.cy = in_d.cy - dy;
        d_nxt.cz = in_d.cz + ATAN;
      end else begin
        d_nxt.cx = in_d.cx - dx;
        d_nxt.cy = in_d.cy + dy;
        d_nxt.cz = in_d.cz - ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule
